FILE: sv/arxh_pkg.sv
// arxh_pkg: shared types, constants and helper functions for the ARX hash stream.
// No dependencies; used by arxh_ctrl, arxh_datapath and arx_hash64_stream.
`default_nettype none

package arxh_pkg;

  // State word initial values and padding marker
  localparam logic [31:0] MIX_A_INIT = 32'h243F6A88;
  localparam logic [31:0] MIX_B_INIT = 32'h85A308D3;
  localparam logic [7:0]  PAD_MARK   = 8'h80;

  // Last word index inside a 32-byte block (the length word)
  localparam logic [2:0]  LEN_WORD_IDX = 3'd7;

  // Last step index of the shared ARX step unit, per word mix and per finalization
  localparam logic [2:0]  WORD_LAST_STEP = 3'd3;
  localparam logic [2:0]  FIN_LAST_STEP  = 3'd7;

  // Which state word a step rewrites
  typedef enum logic {
    OP_A = 1'b0,  // a = rotl(a ^ x, 5) + b
    OP_B = 1'b1   // b = rotl(b + x, 11) ^ a
  } step_op_t;

  // Operand source of a step
  typedef enum logic [1:0] {
    X_WORD,
    X_WORD_ROT16,
    X_CONST
  } x_sel_t;

  // Padding word kinds
  typedef enum logic [1:0] {
    PAD_K_MARK,
    PAD_K_ZERO,
    PAD_K_LEN
  } pad_kind_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      byte_en;   // accepted message byte
    logic      load_pad;  // load a padding word into the mix word register
    pad_kind_t pad_kind;
    logic      step_en;   // run one ARX step
    step_op_t  step_op;
    x_sel_t    x_sel;
    logic [1:0] cidx;     // finalization constant index
    logic      emit;      // latch digest, return state to initial values
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] lane;      // byte position inside the current word
    logic [2:0] word_idx;  // word position inside the current block
  } dp_status_t;

  // Finalization round constants
  function automatic logic [31:0] fin_const(input logic [1:0] idx);
    logic [31:0] c;
    unique case (idx)
      2'd0: c = 32'h13198A2E;
      2'd1: c = 32'h03707344;
      2'd2: c = 32'hA4093822;
      default: c = 32'h299F31D0;
    endcase
    return c;
  endfunction

  // Rotate left by a constant amount (1..31)
  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

endpackage

`default_nettype wire

FILE: sv/arxh_datapath.sv
// arxh_datapath: byte packing, state words, shared ARX step unit, digest register.
// Depends on arxh_pkg; driven by arxh_ctrl commands.
`default_nettype none

module arxh_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [7:0]         data_byte,
  input  wire arxh_pkg::dp_cmd_t  cmd,
  output arxh_pkg::dp_status_t    status,
  output logic [63:0]             digest
);

  logic [31:0] mix_a;
  logic [31:0] mix_b;
  logic [31:0] byte_count;
  logic [23:0] word_gather;
  logic [31:0] mix_word;     // word being mixed, held over its four steps

  logic [31:0] x_val;
  logic [31:0] step_a;
  logic [31:0] step_b;
  logic [31:0] pad_word;
  logic [23:0] gather_next;
  logic [31:0] fin_val;
  logic [4:0]  lane_shift;

  assign status.lane     = byte_count[1:0];
  assign status.word_idx = byte_count[4:2];
  assign lane_shift      = {byte_count[1:0], 3'b000};

  // Step operand select
  always_comb begin
    unique case (cmd.x_sel)
      arxh_pkg::X_WORD:       x_val = mix_word;
      arxh_pkg::X_WORD_ROT16: x_val = {mix_word[15:0], mix_word[31:16]};
      arxh_pkg::X_CONST:      x_val = arxh_pkg::fin_const(cmd.cidx);
      default:                x_val = mix_word;
    endcase
  end

  // One add per step
  assign step_a = arxh_pkg::rotl32(mix_a ^ x_val, 5) + mix_b;
  assign step_b = arxh_pkg::rotl32(mix_b + x_val, 11) ^ mix_a;

  // Byte packing into the gather register
  assign gather_next = word_gather | 24'((32'(data_byte)) << lane_shift);

  // Padding words
  always_comb begin
    unique case (cmd.pad_kind)
      arxh_pkg::PAD_K_MARK:
        pad_word = {8'h00, word_gather} | ((32'(arxh_pkg::PAD_MARK)) << lane_shift);
      arxh_pkg::PAD_K_LEN:
        pad_word = {byte_count[7:0], byte_count[15:8], byte_count[23:16],
                    byte_count[31:24]};
      default:
        pad_word = 32'h0;
    endcase
  end

  assign fin_val = mix_a ^ arxh_pkg::rotl32(mix_b, 3);

  // State words, counters and gather
  always_ff @(posedge clk) begin
    if (rst) begin
      mix_a       <= arxh_pkg::MIX_A_INIT;
      mix_b       <= arxh_pkg::MIX_B_INIT;
      byte_count  <= 32'h0;
      word_gather <= 24'h0;
    end else if (cmd.emit) begin
      mix_a       <= arxh_pkg::MIX_A_INIT;
      mix_b       <= arxh_pkg::MIX_B_INIT;
      byte_count  <= 32'h0;
      word_gather <= 24'h0;
    end else begin
      if (cmd.step_en) begin
        if (cmd.step_op == arxh_pkg::OP_A) begin
          mix_a <= step_a;
        end else begin
          mix_b <= step_b;
        end
      end
      if (cmd.byte_en) begin
        byte_count <= byte_count + 32'd1;
        if (byte_count[1:0] == 2'd3) begin
          word_gather <= 24'h0;
        end else begin
          word_gather <= gather_next;
        end
      end else if (cmd.load_pad && cmd.pad_kind == arxh_pkg::PAD_K_MARK) begin
        word_gather <= 24'h0;
      end
    end
  end

  // Mix word and digest payload registers
  always_ff @(posedge clk) begin
    if (cmd.byte_en && byte_count[1:0] == 2'd3) begin
      mix_word <= {data_byte, word_gather};
    end else if (cmd.load_pad) begin
      mix_word <= pad_word;
    end
    if (cmd.emit) begin
      digest <= {fin_val, mix_b};
    end
  end

endmodule

`default_nettype wire

FILE: sv/arxh_ctrl.sv
// arxh_ctrl: handshake control, mix step sequencing, padding and finalization FSM.
// Depends on arxh_pkg; commands arxh_datapath.
`default_nettype none

module arxh_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 byte_present,
  input  wire logic                 last,
  input  wire logic                 out_ready,
  input  wire arxh_pkg::dp_status_t status,
  output logic                      in_ready,
  output logic                      out_valid,
  output arxh_pkg::dp_cmd_t         cmd
);

  typedef enum logic [1:0] {
    S_RUN,   // taking message bytes
    S_PAD,   // loading padding words
    S_LENW,  // length word mixing, then start finalization
    S_FIN    // finalization rounds, then emit
  } state_t;

  state_t     state;
  logic       busy;       // step unit active
  logic [2:0] step;
  logic       fin_mode;
  logic       pad_first;
  logic [2:0] pad_idx;

  logic                accept;
  logic                word_done;
  logic                load_go;
  logic                fin_go;
  logic                emit_go;
  arxh_pkg::pad_kind_t kind;

  assign in_ready  = (state == S_RUN);
  assign accept    = in_valid && in_ready;
  assign word_done = accept && byte_present && (status.lane == 2'd3);
  assign load_go   = (state == S_PAD) && !busy;
  assign fin_go    = (state == S_LENW) && !busy;
  assign emit_go   = (state == S_FIN) && !busy && (!out_valid || out_ready);

  // Padding word kind from block position
  always_comb begin
    priority if (pad_first) begin
      kind = arxh_pkg::PAD_K_MARK;
    end else if (pad_idx == arxh_pkg::LEN_WORD_IDX) begin
      kind = arxh_pkg::PAD_K_LEN;
    end else begin
      kind = arxh_pkg::PAD_K_ZERO;
    end
  end

  // Command decode
  always_comb begin
    cmd.byte_en  = accept && byte_present;
    cmd.load_pad = load_go;
    cmd.pad_kind = kind;
    cmd.step_en  = busy;
    cmd.step_op  = step[0] ? arxh_pkg::OP_B : arxh_pkg::OP_A;
    if (fin_mode) begin
      cmd.x_sel = arxh_pkg::X_CONST;
    end else if (step == 3'd2) begin
      cmd.x_sel = arxh_pkg::X_WORD_ROT16;
    end else begin
      cmd.x_sel = arxh_pkg::X_WORD;
    end
    cmd.cidx = step[2:1];
    cmd.emit = emit_go;
  end

  // State and step sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      busy      <= 1'b0;
      step      <= 3'd0;
      fin_mode  <= 1'b0;
      pad_first <= 1'b0;
      pad_idx   <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      // step unit
      if (busy) begin
        step <= step + 3'd1;
        if (step == (fin_mode ? arxh_pkg::FIN_LAST_STEP : arxh_pkg::WORD_LAST_STEP)) begin
          busy <= 1'b0;
        end
      end
      if (word_done || load_go) begin
        busy     <= 1'b1;
        step     <= 3'd0;
        fin_mode <= 1'b0;
      end else if (fin_go) begin
        busy     <= 1'b1;
        step     <= 3'd0;
        fin_mode <= 1'b1;
      end

      // output register valid
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_RUN: begin
          if (accept && last) begin
            state     <= S_PAD;
            pad_first <= 1'b1;
          end
        end
        S_PAD: begin
          if (load_go) begin
            pad_first <= 1'b0;
            if (pad_first) begin
              pad_idx <= status.word_idx + 3'd1;
            end else begin
              pad_idx <= pad_idx + 3'd1;
            end
            if (kind == arxh_pkg::PAD_K_LEN) begin
              state <= S_LENW;
            end
          end
        end
        S_LENW: begin
          if (fin_go) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (emit_go) begin
            state <= S_RUN;
          end
        end
        default: state <= S_RUN;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/arx_hash64_stream.sv
// arx_hash64_stream: top level of the streaming 64-bit ARX hash.
// Depends on arxh_pkg, arxh_ctrl and arxh_datapath.
//
//   channel | direction | handshake           | payload
//   input   | in        | in_valid / in_ready | data_byte, byte_present, last
//   output  | out       | out_valid/out_ready | digest
//
// Message bytes are taken one per cycle while in_ready is high; a completed word
// mixes in four steps on the shared step unit while the next bytes are packed.
// At message end input is held off: each padding word is loaded and then mixed in
// four steps, for 2 to 9 words, then the finalization rounds run and the digest is
// emitted; a word mix still running at the last transaction delays the first
// padding load.
// The digest sits in an output register; the next message streams in while it
// waits, and only that message's emit stalls on a digest not yet taken.
// Synchronous reset; no clearing pass.
`default_nettype none

module arx_hash64_stream (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_present,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      digest
);

  arxh_pkg::dp_cmd_t    cmd;
  arxh_pkg::dp_status_t status;

  arxh_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .byte_present (byte_present),
    .last         (last),
    .out_ready    (out_ready),
    .status       (status),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .cmd          (cmd)
  );

  arxh_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .data_byte (data_byte),
    .cmd       (cmd),
    .status    (status),
    .digest    (digest)
  );

`ifndef ASSERT_OFF
  // padding load never overlaps a running mix
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_pad |-> !cmd.step_en)
    else $error("padding word loaded while step unit busy");

  // no message byte during padding or finalization
  a_byte_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.byte_en |-> !(cmd.load_pad || cmd.emit))
    else $error("byte accepted during message end");

  // a digest is never overwritten before its transaction completes
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("digest overwritten");

  // emit presents a result next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emit without out_valid");
`endif

endmodule

`default_nettype wire

FILE: tb/arxh_digest_checker.sv
// arxh_digest_checker: watches both channels of arx_hash64_stream, predicts each digest
// from the accepted byte stream and compares it with what the block delivers.
// No package dependency; instantiated by tb_arx_hash64_stream beside the block.

module arxh_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] digest,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  localparam logic [31:0] SEED_A   = 32'h243F6A88;
  localparam logic [31:0] SEED_B   = 32'h85A308D3;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [31:0] ROUND_K [4] = '{32'h13198A2E, 32'h03707344,
                                           32'hA4093822, 32'h299F31D0};

  // Shadow hash state
  logic [31:0] hash_a;
  logic [31:0] hash_b;
  logic [31:0] msg_len;
  logic [23:0] gather;

  logic [63:0] expected_digests[$];

  function automatic logic [31:0] rot_left(input logic [31:0] v, input int unsigned n);
    logic [63:0] twice;
    twice = {v, v};
    return twice[63-n -: 32];
  endfunction

  task automatic clear_state();
    hash_a  = SEED_A;
    hash_b  = SEED_B;
    msg_len = '0;
    gather  = '0;
  endtask

  // Four ARX steps for one completed word
  task automatic mix_word_in(input logic [31:0] w);
    hash_a = rot_left(hash_a ^ w, 5) + hash_b;
    hash_b = rot_left(hash_b + w, 11) ^ hash_a;
    hash_a = rot_left(hash_a ^ rot_left(w, 16), 5) + hash_b;
    hash_b = rot_left(hash_b + w, 11) ^ hash_a;
  endtask

  // Little-endian packing; the fourth byte of a word triggers the mix
  task automatic place_byte(input logic [7:0] b, input logic [31:0] pos);
    logic [1:0] lane;
    lane = pos[1:0];
    if (lane == 2'd3) begin
      mix_word_in({b, gather});
      gather = '0;
    end else begin
      gather = gather | (24'(b) << (8 * lane));
    end
  endtask

  // Pad to a 32-byte block with the length last, finalize, queue the digest
  task automatic close_message();
    logic [31:0] len;
    logic [31:0] pos;
    logic [31:0] top;
    len = msg_len;
    pos = len;
    place_byte(PAD_BYTE, pos);
    pos++;
    while (pos[4:0] != 5'd28) begin
      place_byte(8'h00, pos);
      pos++;
    end
    place_byte(len[31:24], pos); pos++;
    place_byte(len[23:16], pos); pos++;
    place_byte(len[15:8], pos);  pos++;
    place_byte(len[7:0], pos);
    for (int r = 0; r < 4; r++) begin
      hash_a = rot_left(hash_a ^ ROUND_K[r], 5) + hash_b;
      hash_b = rot_left(hash_b + ROUND_K[r], 11) ^ hash_a;
    end
    top = hash_a ^ rot_left(hash_b, 3);
    expected_digests.push_back({top, hash_b});
    clear_state();
  endtask

  task automatic absorb_item(input logic [7:0] d, input logic p, input logic l);
    if (p) begin
      place_byte(d, msg_len);
      msg_len++;
    end
    if (l) close_message();
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    clear_state();
  end

  // Compare delivered digests first, then fold in the accepted input transaction
  always @(posedge clk) begin : watch
    logic [63:0] want;
    if (rst) begin
      clear_state();
      expected_digests.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_digests.size() == 0) begin
          $error("digest %h delivered with no message closed", digest);
          fail_count++;
        end else begin
          want = expected_digests.pop_front();
          checked++;
          if (digest !== want) begin
            $error("digest mismatch: expected %h, actual %h", want, digest);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) absorb_item(data_byte, byte_present, last);
    end
    pending = expected_digests.size();
  end

endmodule

FILE: tb/tb_arx_hash64_stream.sv
// tb_arx_hash64_stream: stimulus and verdict for the streaming ARX hash block.
// Depends on arx_hash64_stream (with arxh_pkg) and arxh_digest_checker.

module tb_arx_hash64_stream;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 225;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        byte_present = 1'b0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] digest;

  int fail_count;
  int pending;
  int checked;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic hold_req = 1'b0;
  int counted = 0;
  int msgs = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  arx_hash64_stream dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .byte_present (byte_present),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .digest       (digest)
  );

  arxh_digest_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .byte_present (byte_present),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .digest       (digest),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked)
  );

  // Receiver pacing, with an occasional long hold-off on request
  initial begin : rx_pace
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog: cycles without any transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // One input transaction; entered and left at a falling edge
  task automatic send_txn(input logic [7:0] d, input logic p, input logic l);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid  <= 1'b0;
      data_byte <= 8'($urandom);
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= d;
    byte_present <= p;
    last         <= l;
    do @(posedge clk); while (!in_ready);
    counted++;
    @(negedge clk);
  endtask

  // Random message: stray empty transactions in between, last on a byte or on its own
  task automatic send_message(input int len);
    bit tail_on_byte;
    tail_on_byte = (len > 0) && ($urandom_range(99) < 70);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) send_txn(8'($urandom), 1'b0, 1'b0);
      send_txn(8'($urandom), 1'b1, tail_on_byte && (i == len - 1));
    end
    if (!tail_on_byte) send_txn(8'($urandom), 1'b0, 1'b1);
    msgs++;
  endtask

  // Sender stops offering until every digest has been delivered
  task automatic drain_digests();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin : stim
    int len;
    int sel;
    int target;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty message, single extreme bytes, ignored bytes, both last styles
    send_txn(8'h00, 1'b0, 1'b1);
    send_txn(8'h5A, 1'b0, 1'b0);
    send_txn(8'hFF, 1'b1, 1'b1);
    send_txn(8'h00, 1'b1, 1'b1);
    send_txn(8'h00, 1'b1, 1'b0);
    send_txn(8'hFF, 1'b1, 1'b0);
    send_txn(8'hA5, 1'b0, 1'b0);
    send_txn(8'hAA, 1'b1, 1'b0);
    send_txn(8'h55, 1'b1, 1'b0);
    send_txn(8'h3C, 1'b0, 1'b1);
    send_txn(8'h80, 1'b1, 1'b0);
    send_txn(8'h7F, 1'b1, 1'b0);
    send_txn(8'h01, 1'b1, 1'b1);
    send_txn(8'hFF, 1'b0, 1'b1);
    msgs += 6;

    // Random phases: no idling (with one receiver hold-off), sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      drain_digests();
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  hold_req = 1'b1; end
        1: begin tx_idle_pct = 52; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 52; end
        default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
      endcase
      target = counted + PHASE_ITEMS;
      while (counted < target) begin
        sel = $urandom_range(99);
        if (sel < 40)      len = $urandom_range(8);
        else if (sel < 70) len = $urandom_range(36, 24);
        else if (sel < 90) len = $urandom_range(23, 9);
        else               len = $urandom_range(90, 37);
        send_message(len);
      end
    end

    drain_digests();
    repeat (60) @(negedge clk);

    $display("Covered %0d transactions in %0d messages, %0d digests checked,", counted,
             msgs, checked);
    $display("with empty and block-boundary lengths under four pacing modes and a hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
